// ===== src/dmxd_pkg.sv =====
// Shared types and constants for the DMX USB message deframer.
// No dependencies; every other file except dmxd_ram imports this package.
package dmxd_pkg;

  localparam int CHANNELS    = 512;
  localparam int CH_W        = $clog2(CHANNELS);
  localparam int UNI_AW      = CH_W + 1;
  localparam int UNI_DEPTH   = 2 * (2 ** CH_W);
  localparam int IDX_W       = 9;
  localparam int COUNT_W     = 10;
  localparam int LEN_W       = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes (paddr[4:2])
  localparam logic [2:0] REG_START        = 3'd0;
  localparam logic [2:0] REG_END          = 3'd1;
  localparam logic [2:0] REG_DMX_LABEL    = 3'd2;
  localparam logic [2:0] REG_SERIAL_LABEL = 3'd3;
  localparam logic [2:0] REG_PORT_LABEL   = 3'd4;
  localparam logic [2:0] REG_START_CODE   = 3'd5;

  typedef enum logic [2:0] {
    EV_READ      = 3'd0,
    EV_DMX       = 3'd1,
    EV_PORTS     = 3'd2,
    EV_SERIAL    = 3'd3,
    EV_OTHER     = 3'd4,
    EV_BAD_LEN   = 3'd5,
    EV_BAD_START = 3'd6,
    EV_SHORT     = 3'd7
  } event_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LABEL,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_END
  } phase_t;

  typedef enum logic [1:0] {
    CMD_READ,
    CMD_WRITE,
    CMD_FRAME
  } cmd_kind_t;

  typedef struct packed {
    logic [7:0] start_delim;
    logic [7:0] end_delim;
    logic [7:0] dmx_label;
    logic [7:0] serial_label;
    logic [7:0] port_label;
    logic [7:0] start_code;
  } cfg_t;

  // One queued command from the front end to the back end
  typedef struct packed {
    cmd_kind_t           kind;
    event_t              ev;
    logic [7:0]          label;
    logic [7:0]          data;    // write byte, or first payload byte
    logic [IDX_W-1:0]    chan;    // read index or write channel
    logic [COUNT_W-1:0]  count;   // channel count for an accepted DMX frame
    logic [31:0]         serial;
  } cmd_t;

  typedef struct packed {
    event_t              ev;
    logic [7:0]          value;
    logic [COUNT_W-1:0]  count;
    logic [7:0]          label;
    logic [7:0]          ports;
    logic                known;
    logic [31:0]         serial;
  } res_t;

endpackage

// ===== src/dmxd_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module dmxd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== src/dmxd_fifo.sv =====
// Short command queue between the deframer front end and back end.
// Depends on dmxd_pkg for cmd_t and the queue depth.
module dmxd_fifo
  import dmxd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full     = (fill == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== src/dmxd_front.sv =====
// Front end: accepts items, runs the message phase machine and queues commands.
// Depends on dmxd_pkg for the phase, command and configuration types.
module dmxd_front
  import dmxd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             op,
  input  logic [7:0]       rx_byte,
  input  logic [IDX_W-1:0] channel_index,
  input  logic             q_full,
  output logic             push,
  output cmd_t             cmd
);

  phase_t             phase;
  phase_t             phase_next;
  logic [7:0]         label;
  logic [7:0]         label_next;
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   len_next;
  logic [LEN_W-1:0]   pos;
  logic [LEN_W-1:0]   pos_next;
  logic [7:0]         first;
  logic [7:0]         first_next;
  logic [31:0]        serial_asm;
  logic [31:0]        serial_next;
  logic [LEN_W:0]     pos_inc;
  logic [LEN_W-1:0]   len_m1;
  logic [LEN_W-1:0]   len_full;
  logic               is_dmx;
  logic               store_byte;
  logic               acc;
  event_t             frame_ev;

  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;
  assign pos_inc  = {1'b0, pos} + 1'b1;
  assign len_m1   = len - 1'b1;
  assign len_full = {rx_byte, len[7:0]};
  assign is_dmx   = (label == cfg.dmx_label);

  // Keep the byte only for a DMX frame of legal size, channels past the limit dropped
  assign store_byte = is_dmx && (len <= LEN_W'(CHANNELS + 2)) &&
                      (pos != '0) && (pos <= LEN_W'(CHANNELS));

  // Classify a completed frame; DMX label wins, then port count, then serial
  always_comb begin
    frame_ev = EV_OTHER;
    priority if (is_dmx) begin
      priority if (len > LEN_W'(CHANNELS + 2)) frame_ev = EV_BAD_LEN;
      else if (len == '0)                      frame_ev = EV_SHORT;
      else if (first != cfg.start_code)        frame_ev = EV_BAD_START;
      else                                     frame_ev = EV_DMX;
    end else if (label == cfg.port_label) begin
      frame_ev = (len == '0) ? EV_SHORT : EV_PORTS;
    end else if (label == cfg.serial_label) begin
      frame_ev = (len < LEN_W'(4)) ? EV_SHORT : EV_SERIAL;
    end else begin
      frame_ev = EV_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      label      <= '0;
      len        <= '0;
      pos        <= '0;
      first      <= '0;
      serial_asm <= '0;
    end else begin
      phase      <= phase_next;
      label      <= label_next;
      len        <= len_next;
      pos        <= pos_next;
      first      <= first_next;
      serial_asm <= serial_next;
    end
  end

  always_comb begin
    phase_next  = phase;
    label_next  = label;
    len_next    = len;
    pos_next    = pos;
    first_next  = first;
    serial_next = serial_asm;
    push        = 1'b0;
    cmd.kind    = CMD_READ;
    cmd.ev      = frame_ev;
    cmd.label   = label;
    cmd.data    = rx_byte;
    cmd.chan    = channel_index;
    cmd.count   = len_m1[COUNT_W-1:0];
    cmd.serial  = (frame_ev == EV_SERIAL) ? serial_asm : '0;
    if (acc) begin
      if (op) begin
        push     = 1'b1;
        cmd.kind = CMD_READ;
      end else begin
        unique case (phase)
          PH_HUNT: begin
            if (rx_byte == cfg.start_delim) phase_next = PH_LABEL;
          end
          PH_LABEL: begin
            label_next = rx_byte;
            phase_next = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            len_next   = {8'h00, rx_byte};
            phase_next = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            len_next    = len_full;
            pos_next    = '0;
            first_next  = '0;
            serial_next = '0;
            phase_next  = (len_full == '0) ? PH_END : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            if (pos == '0) first_next = rx_byte;
            if (pos < LEN_W'(4)) serial_next[8*pos[1:0] +: 8] = rx_byte;
            if (store_byte) begin
              push     = 1'b1;
              cmd.kind = CMD_WRITE;
              cmd.chan = IDX_W'(pos - 1'b1);
            end
            pos_next = pos_inc[LEN_W-1:0];
            if (pos_inc >= {1'b0, len}) phase_next = PH_END;
          end
          PH_END: begin
            phase_next = PH_HUNT;
            if (rx_byte == cfg.end_delim) begin
              push     = 1'b1;
              cmd.kind = CMD_FRAME;
              cmd.data = first;
            end
          end
          default: phase_next = PH_HUNT;
        endcase
      end
    end
  end

endmodule

// ===== src/dmxd_back.sv =====
// Back end: executes queued commands against the universe store and
// committed state, then holds each result in an output register.
// Depends on dmxd_pkg and dmxd_ram.
module dmxd_back
  import dmxd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  cmd_t q_cmd,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic               bank;
  logic               bank_next;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [7:0]         ports;
  logic [7:0]         ports_next;
  logic               known;
  logic               known_next;

  logic               s1_valid;
  logic               s1_move;
  logic               s1_read;
  logic               s1_hit;
  res_t               s1_res;
  res_t               s1_res_next;
  res_t               s1_out;
  logic               hit;

  logic               ram_en;
  logic               ram_we;
  logic [UNI_AW-1:0]  ram_addr;
  logic [7:0]         ram_rdata;

  assign s1_move = s1_valid && (!out_valid || out_ready);
  assign pop     = !q_empty && (!s1_valid || s1_move);
  assign hit     = ({1'b0, q_cmd.chan} < count) &&
                   ({1'b0, q_cmd.chan} < COUNT_W'(CHANNELS));

  // Committed state moves in command order; writes go to the idle bank
  always_comb begin
    bank_next   = bank;
    count_next  = count;
    ports_next  = ports;
    known_next  = known;
    ram_en      = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = {bank, q_cmd.chan[CH_W-1:0]};
    if (pop) begin
      unique case (q_cmd.kind)
        CMD_READ: begin
          ram_en = 1'b1;
        end
        CMD_WRITE: begin
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = {~bank, q_cmd.chan[CH_W-1:0]};
        end
        CMD_FRAME: begin
          if (q_cmd.ev == EV_DMX) begin
            bank_next  = ~bank;
            count_next = q_cmd.count;
          end
          if (q_cmd.ev == EV_PORTS) begin
            ports_next = q_cmd.data;
            known_next = 1'b1;
          end
        end
        default: ;
      endcase
    end
    s1_res_next.ev     = (q_cmd.kind == CMD_READ) ? EV_READ : q_cmd.ev;
    s1_res_next.value  = '0;
    s1_res_next.count  = count_next;
    s1_res_next.label  = (q_cmd.kind == CMD_READ) ? 8'h00 : q_cmd.label;
    s1_res_next.ports  = ports_next;
    s1_res_next.known  = known_next;
    s1_res_next.serial = (q_cmd.kind == CMD_READ) ? 32'h0 : q_cmd.serial;
  end

  // Merge the registered read data into the staged result
  always_comb begin
    s1_out       = s1_res;
    s1_out.value = (s1_read && s1_hit) ? ram_rdata : 8'h00;
  end

  dmxd_ram #(
    .WIDTH (8),
    .DEPTH (UNI_DEPTH)
  ) u_universe (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (q_cmd.data),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bank      <= 1'b0;
      count     <= '0;
      ports     <= '0;
      known     <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      bank  <= bank_next;
      count <= count_next;
      ports <= ports_next;
      known <= known_next;
      if (pop) begin
        s1_valid <= (q_cmd.kind != CMD_WRITE);
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_res  <= s1_res_next;
      s1_read <= (q_cmd.kind == CMD_READ);
      s1_hit  <= hit;
    end
    if (s1_move) begin
      out_res <= s1_out;
    end
  end

endmodule

// ===== src/dmx_usb_message_deframer.sv =====
// Top level of the DMX USB message deframer: configuration registers,
// front end, command queue and back end. Depends on dmxd_pkg, dmxd_front,
// dmxd_fifo, dmxd_back (and through it dmxd_ram).
//
// The block takes one item per clock while the queue is not full: a received
// link byte (s_tuser low) or a read of a committed channel value (s_tuser high).
// Bytes are deframed as start delimiter, label, 16-bit little-endian length,
// payload and end delimiter; a completed frame yields one result whose kind sits
// in m_tuser, a read yields one read result, and other bytes yield nothing. The
// front end handles an item in its accept cycle and places at most one command
// in a four-entry queue; the back end executes one command per cycle while its
// result path is not stalled, through a single-port universe RAM (two banks of
// 512 bytes, registered read). A result passes from the queue through the
// staging register and then the output register before it reaches m_tvalid,
// and the sustained rate is one item per cycle while m_tready stays high;
// s_tready drops only while the queue is full. The universe RAM needs no
// clearing after reset: only channels below the committed count are ever read,
// and those were written by the frame that committed them.
module dmx_usb_message_deframer
  import dmxd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] rx_byte, [16:8] channel_index, rest zero
  input  logic        s_tuser,   // [0] op
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [7:0] channel_value, [17:8] channel_count,
                                 // [25:18] frame_label, [33:26] port_count,
                                 // [34] port_count_valid, [66:35] serial_number
  output logic [2:0]  m_tuser,   // [2:0] event_res
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  logic cfg_wr;
  logic [7:0] rd_byte;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_in;
  cmd_t q_out;
  res_t res;

  // Configuration registers; a write lands on the access cycle
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_delim  <= 8'd126;
      cfg.end_delim    <= 8'd231;
      cfg.dmx_label    <= 8'd5;
      cfg.serial_label <= 8'd10;
      cfg.port_label   <= 8'd0;
      cfg.start_code   <= 8'd0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_START:        cfg.start_delim  <= pwdata[7:0];
        REG_END:          cfg.end_delim    <= pwdata[7:0];
        REG_DMX_LABEL:    cfg.dmx_label    <= pwdata[7:0];
        REG_SERIAL_LABEL: cfg.serial_label <= pwdata[7:0];
        REG_PORT_LABEL:   cfg.port_label   <= pwdata[7:0];
        REG_START_CODE:   cfg.start_code   <= pwdata[7:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_START:        rd_byte = cfg.start_delim;
      REG_END:          rd_byte = cfg.end_delim;
      REG_DMX_LABEL:    rd_byte = cfg.dmx_label;
      REG_SERIAL_LABEL: rd_byte = cfg.serial_label;
      REG_PORT_LABEL:   rd_byte = cfg.port_label;
      REG_START_CODE:   rd_byte = cfg.start_code;
      default:          rd_byte = 8'h00;
    endcase
  end

  assign prdata = {24'h0, rd_byte};

  // Front end: classify each transaction, advance the phase machine
  dmxd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .op            (s_tuser),
    .rx_byte       (s_tdata[7:0]),
    .channel_index (s_tdata[16:8]),
    .q_full        (q_full),
    .push          (q_push),
    .cmd           (q_in)
  );

  // Queue decouples the two halves so each can stall on its own
  dmxd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // Back end: universe store, bank swap, committed counts, result register
  dmxd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_cmd     (q_out),
    .pop       (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tuser = res.ev;
  assign m_tdata = {5'b0, res.serial, res.known, res.ports, res.label, res.count, res.value};

endmodule
